/* rtl/led_matrix_pattern_scanner_core_assert.svh */
// Assertion macros used by the LED matrix scanner checker
`ifndef LED_MATRIX_PATTERN_SCANNER_CORE_ASSERT_SVH
`define LED_MATRIX_PATTERN_SCANNER_CORE_ASSERT_SVH

// Check that a condition implies another at the same clock edge
`define LMPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another at the following clock edge
`define LMPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lmps_pkg.sv */
// Shared types and constants of the LED matrix pattern scanner
package lmps_pkg;

  // Request operations
  typedef enum logic [1:0] {
    OP_LOAD_ROW   = 2'd0,
    OP_LOAD_WIDTH = 2'd1,
    OP_STEP       = 2'd2,
    OP_SCAN       = 2'd3
  } op_e;

  // Display modes
  localparam logic [2:0] MODE_SLIDE     = 3'd0;
  localparam logic [2:0] MODE_ANIMATE   = 3'd1;
  localparam logic [2:0] MODE_ROT_RIGHT = 3'd2;
  localparam logic [2:0] MODE_ROT_LEFT  = 3'd3;
  localparam logic [2:0] MODE_UPSIDE    = 3'd4;

  // Rotation in quarter turns
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_ROT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd2;

  // Reset values and limits
  localparam logic [2:0]        DISPLAY_MODE_RST  = MODE_ANIMATE;
  localparam logic [4:0]        PATTERN_COUNT_RST = 5'd9;
  localparam logic signed [3:0] SLIDE_POS_TOP     = 4'sd7;
  localparam logic [3:0]        MAX_WIDTH         = 4'd8;
  localparam int unsigned       GLYPH_ID_LIMIT    = 16;
  localparam int unsigned       ROWS              = 8;

endpackage

/* rtl/lmps_ram.sv */
// Generic single-port-write, registered-read RAM
module lmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/led_matrix_pattern_scanner_core.sv */
// A scan request reaches the output through the stage-one and output registers.
// Throughput: one request per cycle when not stalled; glyph rows live in eight row RAMs
// read once per step. The input stalls only while a scan waits behind a result the
// consumer has not taken. Reset clears all state at once: glyph rows through per-entry
// valid bits, widths and frame in flops; no clearing pass is needed.
module led_matrix_pattern_scanner_core #(
  parameter int unsigned GLYPH_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] glyph_index_i,
  input  logic [2:0] row_index_i,
  input  logic [7:0] row_bits_in_i,
  input  logic [3:0] glyph_width_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] column_on_o,
  output logic [7:0] row_drive_o,
  // configuration port
  input  logic                                 cfg_we_i,
  input  logic [lmps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lmps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned SLOTS_USED =
    (GLYPH_SLOTS < lmps_pkg::GLYPH_ID_LIMIT) ? GLYPH_SLOTS : lmps_pkg::GLYPH_ID_LIMIT;
  localparam int unsigned SLOT_AW = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

  typedef enum logic [1:0] {
    S1_SLIDE,
    S1_SHOW,
    S1_SCAN
  } s1_kind_e;

  // Configuration registers
  logic [2:0] display_mode_q;
  logic [1:0] home_rot_q;
  logic [4:0] pattern_count_q;

  // Block state
  logic [3:0]        cur_glyph_q;
  logic signed [3:0] slide_pos_q;
  logic [1:0]        rotation_q;
  logic [2:0]        scan_col_q;
  logic [3:0]        width_q [SLOTS_USED];
  logic [SLOTS_USED-1:0] row_valid_q [lmps_pkg::ROWS];
  logic [7:0]        frame_q [lmps_pkg::ROWS];

  // Stage one registers
  logic       s1_valid_q;
  s1_kind_e   s1_kind_q;
  logic [2:0] s1_bit_q;
  logic [2:0] s1_shift_q;
  logic [2:0] s1_col_q;
  logic [7:0] s1_row_ok_q;

  // Output register
  logic       out_valid_q;
  logic [2:0] column_on_q;
  logic [7:0] row_drive_q;

  logic             in_fire;
  lmps_pkg::op_e    op;
  logic             s1_blocked;
  logic             out_load;
  logic             cur_in_range;
  logic [3:0]       cur_width;
  logic [4:0]       next_sum;
  logic [3:0]       adv_glyph;
  logic signed [4:0] slide_sum;
  logic             slide_wrap;
  logic [3:0]       sl_glyph;
  logic signed [3:0] sl_pos;
  logic [3:0]       gap;
  logic [2:0]       show_shift;
  logic [2:0]       rot_sum;
  logic             step_ok;
  s1_kind_e         step_kind;
  logic [3:0]       rd_glyph;
  logic             rd_in_range;
  logic [SLOT_AW-1:0] rd_addr;
  logic [3:0]       cur_step_d;
  logic signed [3:0] slide_step_d;
  logic [1:0]       rot_step_d;
  logic             step_fire;
  logic             load_fire;
  logic             g_in_range;
  logic [SLOT_AW-1:0] g_addr;
  logic [7:0]       lane_rdata [lmps_pkg::ROWS];
  logic [7:0]       row_data [lmps_pkg::ROWS];
  logic [7:0]       frame_d [lmps_pkg::ROWS];
  logic [2:0]       sel_row;
  logic [7:0]       pick_row;
  logic [7:0]       scan_bits;

  // Handshake
  assign op         = lmps_pkg::op_e'(operation_i);
  assign s1_blocked = s1_valid_q && (s1_kind_q == S1_SCAN) && out_valid_q && out_stall_i;
  assign in_stall_o = s1_blocked;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && (s1_kind_q == S1_SCAN) && !s1_blocked;

  // Width of the current glyph and the index of the glyph after it
  assign cur_in_range = (32'(cur_glyph_q) < SLOTS_USED);
  assign cur_width    = cur_in_range ? width_q[cur_glyph_q[SLOT_AW-1:0]] : 4'd0;
  assign next_sum     = {1'b0, cur_glyph_q} + 5'd1;
  assign adv_glyph    = (next_sum >= pattern_count_q) ? 4'd0 : next_sum[3:0];

  // Slide: move to the next glyph once its columns have all entered
  assign slide_sum  = {slide_pos_q[3], slide_pos_q} + {1'b0, cur_width};
  assign slide_wrap = (slide_sum < 5'sd8);
  assign sl_glyph   = slide_wrap ? adv_glyph : cur_glyph_q;
  assign sl_pos     = slide_wrap ? lmps_pkg::SLIDE_POS_TOP : slide_pos_q;

  // Show: center the glyph by its width
  assign gap        = lmps_pkg::MAX_WIDTH - cur_width;
  assign show_shift = gap[3:1];
  assign rot_sum    = {1'b0, rotation_q} + 3'd2;

  // Decode a frame step under the current mode
  always_comb begin
    step_ok      = 1'b1;
    step_kind    = S1_SHOW;
    rd_glyph     = cur_glyph_q;
    cur_step_d   = adv_glyph;
    slide_step_d = slide_pos_q;
    rot_step_d   = rotation_q;
    case (display_mode_q)
      lmps_pkg::MODE_SLIDE: begin
        step_kind    = S1_SLIDE;
        rd_glyph     = sl_glyph;
        cur_step_d   = sl_glyph;
        slide_step_d = sl_pos - 4'sd1;
      end
      lmps_pkg::MODE_ANIMATE: begin
        rot_step_d = rotation_q;
      end
      lmps_pkg::MODE_ROT_RIGHT: begin
        rot_step_d = rotation_q + 2'd1;
      end
      lmps_pkg::MODE_ROT_LEFT: begin
        rot_step_d = rotation_q + 2'd3;
      end
      lmps_pkg::MODE_UPSIDE: begin
        rot_step_d = (rot_sum > 3'd3) ? {1'b0, home_rot_q[0]} : rot_sum[1:0];
      end
      default: begin
        step_ok    = 1'b0;
        cur_step_d = cur_glyph_q;
      end
    endcase
  end

  assign step_fire   = in_fire && (op == lmps_pkg::OP_STEP) && step_ok;
  assign rd_in_range = (32'(rd_glyph) < SLOTS_USED);
  assign rd_addr     = rd_glyph[SLOT_AW-1:0];
  assign g_in_range  = (32'(glyph_index_i) < SLOTS_USED);
  assign g_addr      = glyph_index_i[SLOT_AW-1:0];
  assign load_fire   = in_fire && (op == lmps_pkg::OP_LOAD_ROW) && g_in_range;

  // One RAM per glyph row, addressed by glyph slot
  for (genvar r = 0; r < lmps_pkg::ROWS; r++) begin : g_lane
    lmps_ram #(
      .WIDTH(8),
      .DEPTH(SLOTS_USED)
    ) u_row_ram (
      .clk_i  (clk_i),
      .we_i   (load_fire && (row_index_i == 3'(r))),
      .waddr_i(g_addr),
      .wdata_i(row_bits_in_i),
      .re_i   (step_fire && rd_in_range),
      .raddr_i(rd_addr),
      .rdata_o(lane_rdata[r])
    );
  end

  // Drop rows that were never written or lie beyond the store, then form the next frame
  always_comb begin
    for (int r = 0; r < lmps_pkg::ROWS; r++) begin
      row_data[r] = s1_row_ok_q[r] ? lane_rdata[r] : 8'd0;
      if (s1_kind_q == S1_SLIDE) begin
        frame_d[r] = {frame_q[r][6:0], row_data[r][s1_bit_q]};
      end else begin
        frame_d[r] = row_data[r] >> s1_shift_q;
      end
    end
  end

  // Read out one column under the rotation
  assign sel_row  = (rotation_q == lmps_pkg::ROT_270) ? ~s1_col_q : s1_col_q;
  assign pick_row = frame_q[sel_row];

  always_comb begin
    for (int r = 0; r < lmps_pkg::ROWS; r++) begin
      case (rotation_q)
        lmps_pkg::ROT_90:  scan_bits[r] = pick_row[r];
        lmps_pkg::ROT_180: scan_bits[r] = frame_q[3'(7 - r)][s1_col_q];
        lmps_pkg::ROT_270: scan_bits[r] = pick_row[3'(7 - r)];
        default:           scan_bits[r] = frame_q[r][~s1_col_q];
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_mode_q  <= lmps_pkg::DISPLAY_MODE_RST;
      home_rot_q      <= lmps_pkg::ROT_0;
      pattern_count_q <= lmps_pkg::PATTERN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lmps_pkg::CFG_DISPLAY_MODE:  display_mode_q  <= cfg_wdata_i[2:0];
        lmps_pkg::CFG_HOME_ROT:      home_rot_q      <= cfg_wdata_i[1:0];
        lmps_pkg::CFG_PATTERN_COUNT: pattern_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Glyph, slide, rotation, scan state: advance at accept, home rotation on mode write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_glyph_q <= 4'd0;
      slide_pos_q <= lmps_pkg::SLIDE_POS_TOP;
      rotation_q  <= lmps_pkg::ROT_0;
      scan_col_q  <= 3'd0;
    end else if (cfg_we_i && (cfg_index_i == lmps_pkg::CFG_DISPLAY_MODE)) begin
      rotation_q <= home_rot_q;
    end else if (step_fire) begin
      cur_glyph_q <= cur_step_d;
      slide_pos_q <= slide_step_d;
      rotation_q  <= rot_step_d;
    end else if (in_fire && (op == lmps_pkg::OP_SCAN)) begin
      scan_col_q <= scan_col_q + 3'd1;
    end
  end

  // Glyph widths and row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS_USED; s++) begin
        width_q[s] <= 4'd0;
      end
      for (int r = 0; r < lmps_pkg::ROWS; r++) begin
        row_valid_q[r] <= '0;
      end
    end else if (in_fire && g_in_range) begin
      if (op == lmps_pkg::OP_LOAD_WIDTH) begin
        width_q[g_addr] <= (glyph_width_i > lmps_pkg::MAX_WIDTH) ?
                           lmps_pkg::MAX_WIDTH : glyph_width_i;
      end
      if (op == lmps_pkg::OP_LOAD_ROW) begin
        row_valid_q[row_index_i][g_addr] <= 1'b1;
      end
    end
  end

  // Stage one: hold a scan while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= S1_SHOW;
    end else if (!s1_blocked) begin
      s1_valid_q <= step_fire || (in_fire && (op == lmps_pkg::OP_SCAN));
      s1_kind_q  <= (op == lmps_pkg::OP_SCAN) ? S1_SCAN : step_kind;
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bit_q   <= sl_pos[2:0];
      s1_shift_q <= show_shift;
      s1_col_q   <= scan_col_q + 3'd1;
      for (int r = 0; r < lmps_pkg::ROWS; r++) begin
        s1_row_ok_q[r] <= rd_in_range && row_valid_q[r][rd_addr];
      end
    end
  end

  // Frame update from the glyph rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < lmps_pkg::ROWS; r++) begin
        frame_q[r] <= 8'd0;
      end
    end else if (s1_valid_q && (s1_kind_q != S1_SCAN)) begin
      for (int r = 0; r < lmps_pkg::ROWS; r++) begin
        frame_q[r] <= frame_d[r];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      column_on_q <= s1_col_q;
      row_drive_q <= scan_bits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign column_on_o = column_on_q;
  assign row_drive_o = row_drive_q;

endmodule

/* rtl/lmps_checker.sv */
// Port-level checker for the LED matrix pattern scanner, bound to the top level
`include "led_matrix_pattern_scanner_core_assert.svh"

module lmps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] operation_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] column_on_o,
  input logic [7:0] row_drive_o
);

  logic       scan_acc;
  logic       out_acc;
  logic [2:0] pending_q;
  logic [2:0] expect_col_q;

  assign scan_acc = in_valid_i && !in_stall_o &&
                    (lmps_pkg::op_e'(operation_i) == lmps_pkg::OP_SCAN);
  assign out_acc  = out_valid_o && !out_stall_i;

  // Count scans accepted but not yet delivered; track the next column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= 3'd0;
      expect_col_q <= 3'd1;
    end else begin
      pending_q <= pending_q + {2'd0, scan_acc} - {2'd0, out_acc};
      if (out_acc) begin
        expect_col_q <= expect_col_q + 3'd1;
      end
    end
  end

  `LMPS_ASSERT_IMPL(a_result_has_scan, out_valid_o, pending_q != 3'd0,
                    "result shown with no scan request behind it")
  `LMPS_ASSERT_IMPL(a_pending_bound, 1'b1, pending_q <= 3'd2,
                    "more than two scan requests in flight")
  `LMPS_ASSERT_IMPL(a_column_order, out_acc, column_on_o == expect_col_q,
                    "scan column out of order")
  `LMPS_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                    "input stalled while output is free")
  `LMPS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(column_on_o) && $stable(row_drive_o),
                    "stalled result changed")

endmodule

bind led_matrix_pattern_scanner_core lmps_checker u_lmps_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the LED matrix pattern scanner core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [2:0]  MODE_SPARE  = 3'd7;

  typedef struct packed {
    logic [2:0] column;
    logic [7:0] rows;
  } column_drive_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_stall_o;
  lmps_pkg::op_e                   operation_i   = lmps_pkg::OP_LOAD_ROW;
  logic [3:0]                      glyph_index_i = '0;
  logic [2:0]                      row_index_i   = '0;
  logic [7:0]                      row_bits_in_i = '0;
  logic [3:0]                      glyph_width_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i   = 1'b0;
  logic [2:0]                      column_on_o;
  logic [7:0]                      row_drive_o;
  logic                            cfg_we_i      = 1'b0;
  logic [lmps_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [lmps_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Shadow copy of the display state
  logic [7:0] shadow_glyphs [lmps_pkg::GLYPH_ID_LIMIT][lmps_pkg::ROWS];
  logic [3:0] shadow_widths [lmps_pkg::GLYPH_ID_LIMIT];
  logic [7:0] shadow_frame  [lmps_pkg::ROWS];
  logic [3:0] shadow_glyph;
  int         shadow_slide;
  logic [1:0] shadow_rot;
  logic [2:0] shadow_col;
  logic [2:0] shadow_mode;
  logic [1:0] shadow_home;
  logic [4:0] shadow_count;

  column_drive_t expected_columns [$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int            stall_left  = 0;
  bit            sender_gaps = 1'b0;
  bit            sink_stalls = 1'b0;

  led_matrix_pattern_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .glyph_index_i (glyph_index_i),
    .row_index_i   (row_index_i),
    .row_bits_in_i (row_bits_in_i),
    .glyph_width_i (glyph_width_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .column_on_o   (column_on_o),
    .row_drive_o   (row_drive_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void note_failure(input string msg);
    if (error_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  // Compare each taken scan result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    column_drive_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_columns.size() == 0) begin
        note_failure($sformatf("unexpected scan result col %0d rows %02h",
                               column_on_o, row_drive_o));
      end else begin
        due = expected_columns.pop_front();
        if (column_on_o !== due.column || row_drive_o !== due.rows)
          note_failure($sformatf("expected col %0d rows %02h, got col %0d rows %02h",
                                 due.column, due.rows, column_on_o, row_drive_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Display predictor
  // ---------------------------------------------------------------------------

  task automatic reset_shadow();
    foreach (shadow_glyphs[g, r]) shadow_glyphs[g][r] = '0;
    foreach (shadow_widths[g]) shadow_widths[g] = '0;
    foreach (shadow_frame[r]) shadow_frame[r] = '0;
    shadow_mode  = lmps_pkg::DISPLAY_MODE_RST;
    shadow_home  = lmps_pkg::ROT_0;
    shadow_count = lmps_pkg::PATTERN_COUNT_RST;
    shadow_glyph = '0;
    shadow_slide = lmps_pkg::SLIDE_POS_TOP;
    shadow_rot   = shadow_home;
    shadow_col   = '0;
  endtask

  // Move to the next glyph of the message, wrapping at the pattern count
  function automatic void next_glyph();
    logic [4:0] nx;
    nx = {1'b0, shadow_glyph} + 5'd1;
    if (nx >= shadow_count) nx = '0;
    shadow_glyph = nx[3:0];
  endfunction

  // Copy the current glyph into the frame, centered by its width, then move to the next glyph
  function automatic void show_glyph();
    int sh;
    sh = (8 - int'(shadow_widths[shadow_glyph])) / 2;
    for (int i = 0; i < lmps_pkg::ROWS; i++)
      shadow_frame[i] = shadow_glyphs[shadow_glyph][i] >> sh;
    next_glyph();
  endfunction

  // Shift the frame left and bring in the next glyph column
  function automatic void slide_frame();
    int gap;
    int bitpos;
    gap = 8 - int'(shadow_widths[shadow_glyph]);
    if (shadow_slide - gap < 0) begin
      next_glyph();
      shadow_slide = lmps_pkg::SLIDE_POS_TOP;
    end
    shadow_slide--;
    bitpos = (shadow_slide + 1) & 7;
    for (int r = 0; r < lmps_pkg::ROWS; r++)
      shadow_frame[r] = {shadow_frame[r][6:0], shadow_glyphs[shadow_glyph][r][bitpos]};
  endfunction

  function automatic void frame_step();
    int turned;
    case (shadow_mode)
      lmps_pkg::MODE_SLIDE:   slide_frame();
      lmps_pkg::MODE_ANIMATE: show_glyph();
      lmps_pkg::MODE_ROT_RIGHT: begin
        shadow_rot = shadow_rot + 2'd1;
        show_glyph();
      end
      lmps_pkg::MODE_ROT_LEFT: begin
        shadow_rot = shadow_rot - 2'd1;
        show_glyph();
      end
      lmps_pkg::MODE_UPSIDE: begin
        turned = int'(shadow_rot) + 2;
        if (turned > 3) shadow_rot = {1'b0, shadow_home[0]};
        else shadow_rot = turned[1:0];
        show_glyph();
      end
      default: ;
    endcase
  endfunction

  // Row bits of one column under the current rotation
  function automatic logic [7:0] column_bits(input logic [2:0] c);
    logic [7:0] d;
    int ci;
    ci = c;
    for (int r = 0; r < lmps_pkg::ROWS; r++) begin
      case (shadow_rot)
        lmps_pkg::ROT_90:  d[r] = shadow_frame[ci][r];
        lmps_pkg::ROT_180: d[r] = shadow_frame[7 - r][ci];
        lmps_pkg::ROT_270: d[r] = shadow_frame[7 - ci][7 - r];
        default:           d[r] = shadow_frame[r][7 - ci];
      endcase
    end
    return d;
  endfunction

  task automatic advance_shadow_matrix(input lmps_pkg::op_e op, input logic [3:0] g,
                                       input logic [2:0] r, input logic [7:0] bits,
                                       input logic [3:0] w);
    case (op)
      lmps_pkg::OP_LOAD_ROW:   shadow_glyphs[g][r] = bits;
      lmps_pkg::OP_LOAD_WIDTH:
        shadow_widths[g] = (w > lmps_pkg::MAX_WIDTH) ? lmps_pkg::MAX_WIDTH : w;
      lmps_pkg::OP_STEP:       frame_step();
      default: begin
        shadow_col = shadow_col + 3'd1;
        expected_columns.push_back('{column: shadow_col, rows: column_bits(shadow_col)});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one request, hold it until taken, then update the predictor
  task automatic send_request(input lmps_pkg::op_e op, input logic [3:0] g,
                              input logic [2:0] r, input logic [7:0] bits,
                              input logic [3:0] w);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    glyph_index_i <= g;
    row_index_i   <= r;
    row_bits_in_i <= bits;
    glyph_width_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_shadow_matrix(op, g, r, bits, w);
  endtask

  task automatic send_random_request();
    int            pick;
    lmps_pkg::op_e op;
    logic [3:0]    w;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = lmps_pkg::OP_LOAD_ROW;
    else if (pick < 45) op = lmps_pkg::OP_LOAD_WIDTH;
    else if (pick < 65) op = lmps_pkg::OP_STEP;
    else op = lmps_pkg::OP_SCAN;
    // Favor legal widths, with some oversized ones to hit the clamp
    w = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_request(op, 4'($urandom), 3'($urandom), 8'($urandom), w);
  endtask

  // Drop valid and wait until every scan result has been taken
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all three registers; home rotation before or after the display mode decides the reload
  task automatic configure(input logic [2:0] mode, input logic [1:0] home,
                           input logic [4:0] count);
    logic [lmps_pkg::CFG_IDX_W-1:0]  idx  [3];
    logic [lmps_pkg::CFG_DATA_W-1:0] data [3];
    if ($urandom_range(0, 1) == 0) begin
      idx[0] = lmps_pkg::CFG_HOME_ROT;      data[0] = {3'($urandom), home};
      idx[1] = lmps_pkg::CFG_DISPLAY_MODE;  data[1] = {2'($urandom), mode};
    end else begin
      idx[0] = lmps_pkg::CFG_DISPLAY_MODE;  data[0] = {2'($urandom), mode};
      idx[1] = lmps_pkg::CFG_HOME_ROT;      data[1] = {3'($urandom), home};
    end
    idx[2] = lmps_pkg::CFG_PATTERN_COUNT; data[2] = count;
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      case (idx[i])
        lmps_pkg::CFG_DISPLAY_MODE: begin
          shadow_mode = data[i][2:0];
          shadow_rot  = shadow_home;
        end
        lmps_pkg::CFG_HOME_ROT:      shadow_home  = data[i][1:0];
        lmps_pkg::CFG_PATTERN_COUNT: shadow_count = data[i][4:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Scan the cleared frame through a full column wrap, then step an empty glyph
  task automatic test_power_on_scan();
    for (int i = 0; i < 8; i++) send_request(lmps_pkg::OP_SCAN, '0, '0, '0, '0);
    send_request(lmps_pkg::OP_STEP, '0, '0, '0, '0);
    send_request(lmps_pkg::OP_SCAN, '0, '0, '0, '0);
  endtask

  // Load extreme rows and widths, including an oversized width that clamps
  task automatic test_load_extremes();
    send_request(lmps_pkg::OP_LOAD_ROW, 4'd1, 3'd0, 8'hFF, 4'd0);
    send_request(lmps_pkg::OP_LOAD_ROW, 4'd1, 3'd3, 8'h81, 4'd0);
    send_request(lmps_pkg::OP_LOAD_ROW, 4'd1, 3'd7, 8'h01, 4'd0);
    send_request(lmps_pkg::OP_LOAD_ROW, 4'd15, 3'd7, 8'hFF, 4'd0);
    send_request(lmps_pkg::OP_LOAD_WIDTH, 4'd1, 3'd0, 8'h00, 4'd15);
    send_request(lmps_pkg::OP_LOAD_WIDTH, 4'd15, 3'd0, 8'h00, 4'd0);
    send_request(lmps_pkg::OP_LOAD_WIDTH, 4'd2, 3'd0, 8'h00, 4'd5);
    send_request(lmps_pkg::OP_STEP, '0, '0, '0, '0);
    for (int i = 0; i < 8; i++) send_request(lmps_pkg::OP_SCAN, '0, '0, '0, '0);
  endtask

  // A frame step in an unused mode leaves the frame alone
  task automatic test_unused_mode();
    wait_for_idle();
    configure(MODE_SPARE, lmps_pkg::ROT_270, 5'd9);
    send_request(lmps_pkg::OP_STEP, '0, '0, '0, '0);
    send_request(lmps_pkg::OP_SCAN, '0, '0, '0, '0);
  endtask

  // Sweep every mode with varied rotation and pattern counts under random traffic
  task automatic test_mode_sweep();
    logic [4:0] counts [8];
    logic [1:0] home;
    counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd2, 5'd17, 5'd5};
    for (int phase = 0; phase < 14; phase++) begin
      wait_for_idle();
      if (phase == 0) home = lmps_pkg::ROT_0;
      else if (phase == 1) home = lmps_pkg::ROT_270;
      else home = 2'($urandom);
      configure(3'(phase % 8), home,
                (phase < 8) ? counts[phase] : 5'($urandom_range(1, 16)));
      sender_gaps = (phase % 5 != 4);
      sink_stalls = (phase % 5 != 4);
      for (int i = 0; i < 50; i++) begin
        send_random_request();
        // Hold off mid-phase until the display has caught up
        if (phase == 2 && i == 25) wait_for_idle();
      end
    end
  endtask

  // Run at full rate on both sides to close out
  task automatic test_full_rate();
    wait_for_idle();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    configure(lmps_pkg::MODE_SLIDE, 2'($urandom), 5'($urandom_range(1, 16)));
    for (int i = 0; i < 60; i++) send_random_request();
  endtask

  initial begin
    reset_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_power_on_scan();
    test_load_extremes();
    test_unused_mode();
    test_mode_sweep();
    test_full_rate();

    wait_for_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
